FILE: rtl/radix_integer_to_ascii_unit_defines.svh
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_unit_defines.svh
// Assertion macros shared by the radix integer to ASCII unit.
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TO_ASCII_UNIT_DEFINES_SVH
`define RADIX_INTEGER_TO_ASCII_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RITOA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ritoa_pkg.sv
// ----------------------------------------------------------------------------
// ritoa_pkg
// Shared types, constants and helper functions of the radix integer to ASCII
// unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ritoa_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int RADIX_W        = 6;
  localparam int DIGIT_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int COUNT_W        = 7;
  localparam int STORE_DEPTH    = 64;
  localparam int ADDR_W         = 6;
  localparam int OUT_DATA_W     = 16;
  localparam int BITS_PER_STEP  = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
  localparam logic [DIGIT_W-1:0] DECIMAL_BASE = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_LETTER  = 7'd65;

  typedef struct packed {
    logic load;
    logic step;
    logic store;
    logic rd;
    logic next;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic quo_zero;
    logic store_full;
    logic rd_last;
  } stat_t;

  function automatic logic [RADIX_W-1:0] legal_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_BASE) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_LETTER + {1'b0, d} - {1'b0, DECIMAL_BASE};
    end
    return c;
  endfunction

endpackage

FILE: rtl/ritoa_ram.sv
// ----------------------------------------------------------------------------
// ritoa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ritoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ritoa_ctrl.sv
// ----------------------------------------------------------------------------
// ritoa_ctrl
// Sequencer: accepts a request, runs the digit divider per digit, then reads
// the digit store back most significant first onto the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ritoa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ritoa_pkg::stat_t  stat,
  output ritoa_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_READ,
    S_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (stat.quo_zero || stat.store_full) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_READ: begin
        cmd.rd        = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (stat.rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/ritoa_dpath.sv
// ----------------------------------------------------------------------------
// ritoa_dpath
// Datapath: restoring divider (four quotient bits per cycle), digit store,
// digit counters and ASCII mapping of the read-back digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ritoa_dpath #(
  parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ritoa_pkg::cmd_t                   cmd,
  output ritoa_pkg::stat_t                  stat,
  input  logic [VALUE_BITS-1:0]             in_value,
  input  logic [ritoa_pkg::RADIX_W-1:0]     in_radix,
  output logic [ritoa_pkg::CHAR_W-1:0]      digit_char,
  output logic [ritoa_pkg::COUNT_W-1:0]     digit_count,
  output logic                              last_digit
);

  localparam int BPS   = ritoa_pkg::BITS_PER_STEP;
  localparam int QW    = ((VALUE_BITS + BPS - 1) / BPS) * BPS;
  localparam int STEPS = QW / BPS;
  localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int DW    = ritoa_pkg::DIGIT_W;
  localparam int CW    = ritoa_pkg::COUNT_W;
  localparam int AW    = ritoa_pkg::ADDR_W;

  logic [QW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   base_r;
  logic [SCW-1:0]  step_r;
  logic [CW-1:0]   n_r;
  logic [AW-1:0]   k_r;
  logic [CW-1:0]   rd_idx;
  logic [DW-1:0]   rd_digit;

  // four restoring division steps on the remainder
  always_comb begin
    logic [DW:0]    t;
    logic [DW-1:0]  r;
    logic [BPS-1:0] qb;
    r  = rem_r;
    qb = '0;
    for (int i = 0; i < BPS; i++) begin
      t = {r, quo_r[QW-1-i]};
      if (t >= {1'b0, base_r}) begin
        r             = DW'(t - {1'b0, base_r});
        qb[BPS-1-i]   = 1'b1;
      end else begin
        r             = t[DW-1:0];
        qb[BPS-1-i]   = 1'b0;
      end
    end
    rem_nxt = r;
    quo_nxt = {quo_r[QW-BPS-1:0], qb};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r  <= QW'(in_value);
      rem_r  <= '0;
      base_r <= ritoa_pkg::legal_radix(in_radix);
    end else if (cmd.step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end else if (cmd.store) begin
      rem_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      n_r    <= '0;
      k_r    <= '0;
    end else begin
      if (cmd.load) begin
        step_r <= '0;
        n_r    <= '0;
        k_r    <= '0;
      end else begin
        if (cmd.step) begin
          step_r <= stat.step_last ? '0 : step_r + SCW'(1);
        end
        if (cmd.store) begin
          n_r <= n_r + CW'(1);
        end
        if (cmd.next) begin
          k_r <= k_r + AW'(1);
        end
      end
    end
  end

  assign rd_idx = n_r - CW'(1) - CW'(k_r);

  ritoa_ram #(
    .WIDTH (DW),
    .DEPTH (ritoa_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (n_r[AW-1:0]),
    .wdata (rem_r),
    .re    (cmd.rd),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_digit)
  );

  assign stat.step_last  = (step_r == SCW'(STEPS - 1));
  assign stat.quo_zero   = (quo_r == '0);
  assign stat.store_full = (n_r == CW'(ritoa_pkg::STORE_DEPTH - 1));
  assign stat.rd_last    = ((CW'(k_r) + CW'(1)) == n_r);

  assign digit_char  = ritoa_pkg::ascii_of(rd_digit);
  assign digit_count = n_r;
  assign last_digit  = stat.rd_last;

endmodule

FILE: rtl/radix_integer_to_ascii_unit.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_unit
// Converts an unsigned integer to ASCII digits in a radix from 2 to 36.
// ----------------------------------------------------------------------------
// Usage:
//   A request on in_* carries a value and a radix (0/1 act as 2, above 36 as
//   36). The unit then sends one out_* item per digit, most significant
//   first: ASCII char ('0'-'9', 'A'-'Z'), total digit count, and out_tlast
//   on the final digit. A zero value gives the single digit '0'.
//   One request at a time: in_tready is high only while idle.
// Operation:
//   Each digit runs the value through the one shared restoring divider (four
//   quotient bits per cycle), then stores the remainder as the digit.
//   Readback takes each digit from the store, then the output register.
//   A 64-bit value in decimal gives at most 20 digits.
// Reset:
//   Synchronous active-low rst_n returns the sequencer to idle, drops
//   out_tvalid and clears the digit counters. The digit store is not cleared.
// Stall:
//   A stalled out_tready holds the current digit; the unit waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radix_integer_to_ascii_unit_defines.svh"

module radix_integer_to_ascii_unit #(
  parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEF,
  localparam int IN_W = ((VALUE_BITS + ritoa_pkg::RADIX_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [VALUE_BITS-1:0] value, next 6 bits radix, zero fill above
  input  logic [IN_W-1:0]                  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [6:0] digit_char, [13:7] digit_count, [15:14] zero
  output logic [ritoa_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  localparam int RW = ritoa_pkg::RADIX_W;
  localparam int CH = ritoa_pkg::CHAR_W;
  localparam int CW = ritoa_pkg::COUNT_W;

  ritoa_pkg::cmd_t  cmd;
  ritoa_pkg::stat_t stat;
  logic [CH-1:0]    digit_char;
  logic [CW-1:0]    digit_count;
  logic             last_digit;

  ritoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ritoa_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_value    (in_tdata[VALUE_BITS-1:0]),
    .in_radix    (in_tdata[VALUE_BITS +: RW]),
    .digit_char  (digit_char),
    .digit_count (digit_count),
    .last_digit  (last_digit)
  );

  assign out_tdata = {(ritoa_pkg::OUT_DATA_W - CH - CW)'(0), digit_count, digit_char};
  assign out_tlast = last_digit;

  `RITOA_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready && !out_tvalid, "request not followed by busy")
  `RITOA_ASSERT_NEXT(a_idle_after_last, out_tvalid && out_tready && out_tlast, in_tready, "no return to idle after last digit")
  `RITOA_ASSERT_NOW(a_count_nonzero, out_tvalid, digit_count != '0, "digit count zero on output")
  `RITOA_ASSERT_NOW(a_no_overlap, out_tvalid, !in_tready, "input ready while sending digits")

endmodule

FILE: tb/sv/radix_integer_to_ascii_unit_tb.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_unit_tb
// Self-checking bench for the radix integer to ASCII unit. Value/radix
// requests go in on in_*. Every digit that comes out on out_* is matched
// in order against a software conversion of the same request. The stimulus
// covers zero values, full-width values, radix clamping, letter digits, a
// long output hold-off and a random mix with idle bursts on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_integer_to_ascii_unit_tb;

  localparam int RADIX_W     = ritoa_pkg::RADIX_W;
  localparam int DIGIT_W     = ritoa_pkg::DIGIT_W;
  localparam int CHAR_W      = ritoa_pkg::CHAR_W;
  localparam int COUNT_W     = ritoa_pkg::COUNT_W;
  localparam int OUT_DATA_W  = ritoa_pkg::OUT_DATA_W;
  localparam int STORE_DEPTH = ritoa_pkg::STORE_DEPTH;

  localparam logic [RADIX_W-1:0] RADIX_MIN    = ritoa_pkg::RADIX_MIN;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = ritoa_pkg::RADIX_MAX;
  localparam logic [DIGIT_W-1:0] DECIMAL_BASE = ritoa_pkg::DECIMAL_BASE;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = ritoa_pkg::CHAR_ZERO;
  localparam logic [CHAR_W-1:0]  CHAR_LETTER  = ritoa_pkg::CHAR_LETTER;

  localparam int VBITS = 64;
  localparam int IN_W  = ((VBITS + RADIX_W + 7) / 8) * 8;

  typedef struct {
    logic [CHAR_W-1:0]  digit_char;
    logic [COUNT_W-1:0] digit_count;
    logic               last_digit;
  } digit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // [63:0] value, [69:64] radix, [71:70] zero
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [6:0] digit_char, [13:7] digit_count, [15:14] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;

  digit_t pending_digits[$];
  int     error_count = 0;
  bit     steady = 1'b0;
  int     hold_request = 0;
  int     hold_left = 0;
  int     stall_left = 0;

  radix_integer_to_ascii_unit #(.VALUE_BITS(VBITS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // digits of one request, most significant first
  function automatic void predict_digits(input logic [VBITS-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
    logic [63:0]        quo;
    logic [63:0]        base;
    logic [DIGIT_W-1:0] rems[STORE_DEPTH];
    int                 n;
    digit_t             d;
    if (radix < RADIX_MIN) begin
      base = 64'(RADIX_MIN);
    end else if (radix > RADIX_MAX) begin
      base = 64'(RADIX_MAX);
    end else begin
      base = 64'(radix);
    end
    quo = 64'(value);
    n = 0;
    do begin
      rems[n] = DIGIT_W'(quo % base);
      quo = quo / base;
      n++;
    end while (quo != 0 && n < STORE_DEPTH);
    for (int k = n - 1; k >= 0; k--) begin
      if (rems[k] < DECIMAL_BASE) begin
        d.digit_char = CHAR_ZERO + CHAR_W'(rems[k]);
      end else begin
        d.digit_char = CHAR_LETTER + CHAR_W'(rems[k]) - CHAR_W'(DECIMAL_BASE);
      end
      d.digit_count = COUNT_W'(n);
      d.last_digit  = (k == 0);
      pending_digits.push_back(d);
    end
  endfunction

  task automatic send_request(input logic [VBITS-1:0] value,
                              input logic [RADIX_W-1:0] radix);
    int gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(IN_W - VBITS - RADIX_W){1'b0}}, radix, value};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_digits(value, radix);
  endtask

  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  task automatic random_request(output logic [VBITS-1:0] value,
                                output logic [RADIX_W-1:0] radix);
    int sel;
    int w;
    sel = $urandom_range(0, 19);
    w = $urandom_range(1, VBITS);
    value = {$urandom, $urandom};
    value = value & ({VBITS{1'b1}} >> (VBITS - w));
    if (sel == 0) value = '0;
    if (sel == 1) value = '1;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      radix = RADIX_W'($urandom_range(0, 63));
    end else if (sel < 5) begin
      radix = RADIX_W'($urandom_range(2, 36));
    end else begin
      case ($urandom_range(0, 2))
        0: radix = 6'd2;
        1: radix = 6'd10;
        default: radix = 6'd16;
      endcase
    end
  endtask

  always @(posedge clk) begin
    digit_t exp_d;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_digits.size() == 0) begin
          $display("%0t: unexpected digit char=%0d count=%0d last=%0b", $time,
                   out_tdata[6:0], out_tdata[13:7], out_tlast);
          error_count++;
        end else begin
          exp_d = pending_digits.pop_front();
          if (out_tdata[6:0] !== exp_d.digit_char) begin
            $display("%0t: digit_char expected %0d actual %0d", $time,
                     exp_d.digit_char, out_tdata[6:0]);
            error_count++;
          end
          if (out_tdata[13:7] !== exp_d.digit_count) begin
            $display("%0t: digit_count expected %0d actual %0d", $time,
                     exp_d.digit_count, out_tdata[13:7]);
            error_count++;
          end
          if (out_tlast !== exp_d.last_digit) begin
            $display("%0t: last_digit expected %0b actual %0b", $time,
                     exp_d.last_digit, out_tlast);
            error_count++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic test_zero_value();
    send_request('0, 6'd10);
    send_request('0, 6'd2);
    send_request('0, 6'd36);
    drain_outputs();
  endtask

  task automatic test_value_extremes();
    send_request('1, 6'd2);
    send_request('1, 6'd10);
    send_request('1, 6'd16);
    send_request('1, 6'd36);
    send_request(64'd1, 6'd2);
    send_request(64'h8000_0000_0000_0000, 6'd2);
    drain_outputs();
  endtask

  task automatic test_radix_clamping();
    send_request(64'd255, 6'd0);
    send_request(64'd255, 6'd1);
    send_request(64'd35, 6'd37);
    send_request(64'd1295, 6'd63);
    drain_outputs();
  endtask

  task automatic test_letter_digits();
    send_request(64'd35, 6'd36);
    send_request(64'd10, 6'd11);
    send_request(64'h0123_4567_89AB_CDEF, 6'd16);
    send_request(64'd9, 6'd10);
    send_request(64'd36, 6'd36);
    drain_outputs();
  endtask

  // output held off while the next requests wait at the input
  task automatic test_output_holdoff();
    hold_request = 600;
    send_request('1, 6'd10);
    send_request(64'd12345, 6'd7);
    send_request('1, 6'd3);
    drain_outputs();
  endtask

  task automatic test_random_mix(input int count, input bit no_idle);
    logic [VBITS-1:0]   value;
    logic [RADIX_W-1:0] radix;
    steady = no_idle;
    for (int i = 0; i < count; i++) begin
      random_request(value, radix);
      send_request(value, radix);
    end
    drain_outputs();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_value();
    test_value_extremes();
    test_radix_clamping();
    test_letter_digits();
    test_output_holdoff();
    test_random_mix(340, 1'b0);
    test_random_mix(60, 1'b1);
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_digits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
